// ===== src/bfs_pkg.sv =====
// shared types, codes and fixed-point helpers of the boid flocking step
package bfs_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_COH_RADIUS = 3'd0,
    REG_COH_GAIN   = 3'd1,
    REG_SEP_RADIUS = 3'd2,
    REG_SEP_GAIN   = 3'd3,
    REG_ALI_RADIUS = 3'd4,
    REG_ALI_GAIN   = 3'd5,
    REG_TIME_STEP  = 3'd6
  } reg_idx_t;

  // distance result of one scanned boid
  typedef struct packed {
    logic        vld;
    logic [65:0] sq_sum;
    logic [95:0] src;
  } near_t;

  // drop 16 fraction bits of a product, rounding toward zero
  function automatic logic signed [44:0] rtz(input logic signed [60:0] p);
    logic signed [60:0] t;
    t = p + (p[60] ? 61'sh0FFFF : 61'sh0);
    return 45'(t >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
    logic signed [31:0] r;
    if (x > 46'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -46'sh0_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== src/bfs_near.sv =====
// pipelined squared distance between a scanned boid and the current boid
module bfs_near (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [95:0]      pos_a,
  input  logic [95:0]      pos_b,
  input  logic [95:0]      src,
  output bfs_pkg::near_t   res
);
  import bfs_pkg::*;

  logic        v2, v3;
  logic [31:0] ad [3];
  logic [31:0] mag [3];
  logic [63:0] sq [3];
  logic [95:0] src2, src3;

  always_comb begin
    logic signed [32:0] d;
    for (int k = 0; k < 3; k++) begin
      d = 33'($signed(pos_a[32*k +: 32])) - 33'($signed(pos_b[32*k +: 32]));
      mag[k] = d[32] ? 32'(-d) : d[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= in_vld;
      v3 <= v2;
    end
    for (int k = 0; k < 3; k++) begin
      ad[k] <= mag[k];
      sq[k] <= ad[k] * ad[k];
    end
    src2 <= src;
    src3 <= src2;
  end

  assign res.vld    = v3;
  assign res.sq_sum = 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
  assign res.src    = src3;

endmodule

// ===== src/bfs_div.sv =====
// restoring divider, one quotient bit a cycle, quotient truncated toward zero
module bfs_div #(
  parameter int SW = 39,
  parameter int CW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [SW-1:0] num,
  input  logic [CW-1:0]       den,
  output logic                done,
  output logic signed [32:0]  quo
);
  localparam int SCW = $clog2(SW + 1);

  logic [SCW-1:0] steps;
  logic           busy;
  logic           neg;
  logic [SW-1:0]  q;
  logic [CW-1:0]  rem;
  logic [CW-1:0]  den_r;
  logic [CW:0]    r_sh;
  logic           fit;

  assign r_sh = {rem, q[SW-1]};
  assign fit  = r_sh >= {1'b0, den_r};
  assign quo  = neg ? -33'(q) : 33'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SCW'(SW);
        neg   <= num[SW-1];
        q     <= num[SW-1] ? SW'(-num) : SW'(num);
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        q     <= {q[SW-2:0], fit};
        rem   <= fit ? CW'(r_sh - {1'b0, den_r}) : r_sh[CW-1:0];
        steps <= steps - 1'b1;
        if (steps == SCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/boid_flocking_step.sv =====
// top level: boid stores, step sequencer, shared multiplier and dividers
// Keeps NUM_BOIDS boids (position and velocity, signed Q16.16) in two memories
// with a registered read. After reset a clearing pass zeroes both memories
// before the first request is taken. A load writes both memories as it is taken;
// a read passes the registered memory data to the output register; a result waits
// there while further requests are taken, and a second read holds until that
// register is free. A step runs two passes over all boids, each boid a full scan
// of the memory (one boid a cycle through a distance pipeline) followed by mean
// division on three 1-bit-a-cycle dividers and its update on one shared multiplier.
module boid_flocking_step #(
  parameter int NUM_BOIDS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // boid_index, in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z, pad
  input  logic [199:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);
  import bfs_pkg::*;

  localparam int AW = $clog2(NUM_BOIDS);
  localparam int CW = AW + 1;
  localparam int SW = 32 + AW;
  localparam logic [AW-1:0] LAST = AW'(NUM_BOIDS - 1);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_RD       = 11'b000_0000_0100,
    S_OWN      = 11'b000_0000_1000,
    S_OWN_W    = 11'b000_0001_0000,
    S_SCAN     = 11'b000_0010_0000,
    S_DRAIN    = 11'b000_0100_0000,
    S_DIV_GO   = 11'b000_1000_0000,
    S_DIV_WAIT = 11'b001_0000_0000,
    S_APPLY    = 11'b010_0000_0000,
    S_WRITE    = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [15:0]        coh_r, sep_r, ali_r;
  logic signed [17:0] coh_g, sep_g, ali_g;
  logic [23:0]        ts;
  logic [63:0]        lim1, lim2;

  // memories
  logic [95:0] pos_mem [NUM_BOIDS];
  logic [95:0] vel_mem [NUM_BOIDS];
  logic [95:0] pos_rd, vel_rd, pos_wd, vel_wd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic pos_we, vel_we;

  // sequencer
  logic [AW-1:0] i, j, rd_idx;
  logic          pass, rnd, rd_ok, p1;
  logic [1:0]    dr, k;
  logic [2:0]    ph;
  logic [95:0]   own_p, own_v;
  logic signed [31:0] own_pos [3];
  logic signed [31:0] own_vel [3];

  // accumulation and means
  logic signed [SW-1:0] acc1 [3];
  logic signed [SW-1:0] acc2 [3];
  logic [CW-1:0]        cnt1, cnt2;
  logic signed [32:0]   m1 [3];
  logic signed [32:0]   m2 [3];
  logic [2:0]           div_done;
  logic signed [32:0]   quo [3];

  // arithmetic
  logic signed [35:0] mul_a, dm1, dm2, dva, fsum;
  logic signed [24:0] mul_b;
  logic signed [60:0] prod;
  logic signed [44:0] t1;
  logic signed [31:0] vnew [3];
  logic signed [31:0] pnew [3];

  near_t near_res;
  logic  near1, near2;

  logic        acc_in;
  kind_t       in_kind;
  logic [6:0]  in_idx;
  logic        idx_ok;

  assign in_kind       = kind_t'(s_axis_tuser);
  assign in_idx        = s_axis_tdata[6:0];
  assign idx_ok        = int'(in_idx) < NUM_BOIDS;
  assign s_axis_tready = (state == S_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      own_pos[n] = $signed(own_p[32*n +: 32]);
      own_vel[n] = $signed(own_v[32*n +: 32]);
    end
  end

  // memory port control
  always_comb begin
    rd_addr = i;
    wr_addr = i;
    pos_we  = 1'b0;
    vel_we  = 1'b0;
    pos_wd  = '0;
    vel_wd  = '0;
    case (state)
      S_CLEAR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
      end
      S_IDLE: begin
        rd_addr = AW'(in_idx);
        wr_addr = AW'(in_idx);
        if (acc_in && in_kind == KIND_LOAD && idx_ok) begin
          pos_we = 1'b1;
          vel_we = 1'b1;
          pos_wd = s_axis_tdata[102:7];
          vel_wd = s_axis_tdata[198:103];
        end
      end
      // keep the read data while the output register is busy
      S_RD: rd_addr = rd_idx;
      S_SCAN: rd_addr = j;
      S_WRITE: begin
        vel_we = 1'b1;
        vel_wd = {vnew[2], vnew[1], vnew[0]};
        pos_we = pass;
        pos_wd = {pnew[2], pnew[1], pnew[0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    if (vel_we) vel_mem[wr_addr] <= vel_wd;
    pos_rd <= pos_mem[rd_addr];
    vel_rd <= vel_mem[rd_addr];
  end

  bfs_near u_near (
    .clk    (clk),
    .rst    (rst),
    .in_vld (p1),
    .pos_a  (pos_rd),
    .pos_b  (own_p),
    .src    (pass ? vel_rd : pos_rd),
    .res    (near_res)
  );

  assign near1 = near_res.sq_sum < {2'b00, lim1};
  assign near2 = near_res.sq_sum < {2'b00, lim2};

  for (genvar g = 0; g < 3; g++) begin : g_div
    bfs_div #(.SW(SW), .CW(CW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (state == S_DIV_GO),
      .num   (rnd ? acc2[g] : acc1[g]),
      .den   (rnd ? cnt2 : cnt1),
      .done  (div_done[g]),
      .quo   (quo[g])
    );
  end

  // shared multiplier operands
  assign dm1 = 36'(m1[k]) - 36'(own_pos[k]);
  assign dm2 = 36'(m2[k]) - 36'(own_pos[k]);
  assign dva = 36'(m1[k]) - 36'(own_vel[k]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (!pass) begin
      case (ph)
        3'd0: begin mul_a = dm1;  mul_b = 25'(coh_g); end
        3'd1: begin mul_a = dm2;  mul_b = 25'(sep_g); end
        3'd3: begin mul_a = fsum; mul_b = $signed({1'b0, ts}); end
        default: ;
      endcase
    end else begin
      case (ph)
        3'd0: begin mul_a = dva;            mul_b = 25'(ali_g); end
        3'd2: begin mul_a = 36'(vnew[k]);   mul_b = $signed({1'b0, ts}); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (near_res.vld) begin
      for (int n = 0; n < 3; n++) begin
        if (near1) acc1[n] <= acc1[n] + SW'($signed(near_res.src[32*n +: 32]));
        if (near2) acc2[n] <= acc2[n] + SW'($signed(near_res.src[32*n +: 32]));
      end
      if (near1) cnt1 <= cnt1 + 1'b1;
      if (near2) cnt2 <= cnt2 + 1'b1;
    end
    if (state == S_OWN_W) begin
      for (int n = 0; n < 3; n++) begin
        acc1[n] <= '0;
        acc2[n] <= '0;
      end
      cnt1 <= '0;
      cnt2 <= '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      i             <= '0;
      p1            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      coh_r         <= 16'd100;
      coh_g         <= 18'sd66;
      sep_r         <= 16'd30;
      sep_g         <= -18'sd328;
      ali_r         <= 16'd70;
      ali_g         <= 18'sd1311;
      ts            <= 24'd65536;
    end else begin
      p1 <= (state == S_SCAN);
      if (state == S_RD && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_COH_RADIUS: coh_r <= cfg_data[15:0];
          REG_COH_GAIN:   coh_g <= $signed(cfg_data[17:0]);
          REG_SEP_RADIUS: sep_r <= cfg_data[15:0];
          REG_SEP_GAIN:   sep_g <= $signed(cfg_data[17:0]);
          REG_ALI_RADIUS: ali_r <= cfg_data[15:0];
          REG_ALI_GAIN:   ali_g <= $signed(cfg_data[17:0]);
          REG_TIME_STEP:  ts    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          if (i == LAST) begin
            i     <= '0;
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_IDLE: begin
          if (acc_in) begin
            case (in_kind)
              KIND_STEP: begin
                pass  <= 1'b0;
                i     <= '0;
                lim1  <= {32'(coh_r) * 32'(coh_r), 32'b0};
                lim2  <= {32'(sep_r) * 32'(sep_r), 32'b0};
                state <= S_OWN;
              end
              KIND_READ: begin
                rd_ok  <= idx_ok;
                rd_idx <= AW'(in_idx);
                state  <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= rd_ok ? {vel_rd, pos_rd} : '0;
            state        <= S_IDLE;
          end
        end
        S_OWN: state <= S_OWN_W;
        S_OWN_W: begin
          own_p <= pos_rd;
          own_v <= vel_rd;
          j     <= '0;
          rnd   <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          dr <= '0;
          if (j == LAST) state <= S_DRAIN;
          else j <= j + 1'b1;
        end
        S_DRAIN: begin
          // last scanned boid leaves the distance pipeline
          if (dr == 2'd2) state <= S_DIV_GO;
          else dr <= dr + 1'b1;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done[0]) begin
            for (int n = 0; n < 3; n++) begin
              if (rnd) m2[n] <= quo[n];
              else m1[n] <= quo[n];
            end
            if (!pass && !rnd) begin
              rnd   <= 1'b1;
              state <= S_DIV_GO;
            end else begin
              k     <= '0;
              ph    <= '0;
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          if (!pass) begin
            case (ph)
              3'd1: t1 <= (cnt1 != '0) ? rtz(prod) : '0;
              3'd2: fsum <= 36'(t1 + ((cnt2 != '0) ? rtz(prod) : 45'sd0));
              3'd4: vnew[k] <= sat32(46'(own_vel[k]) + 46'(rtz(prod)));
              default: ;
            endcase
          end else begin
            case (ph)
              3'd1: vnew[k] <= (cnt1 != '0) ?
                               sat32(46'(own_vel[k]) + 46'(rtz(prod))) : own_vel[k];
              3'd3: pnew[k] <= sat32(46'(own_pos[k]) + 46'(rtz(prod)));
              default: ;
            endcase
          end
          if (ph == (pass ? 3'd3 : 3'd4)) begin
            ph <= '0;
            if (k == 2'd2) state <= S_WRITE;
            else k <= k + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_WRITE: begin
          if (i == LAST) begin
            i <= '0;
            if (!pass) begin
              pass  <= 1'b1;
              lim1  <= {32'(ali_r) * 32'(ali_r), 32'b0};
              state <= S_OWN;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_OWN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_GO |-> (!p1 && !near_res.vld))
    else $error("division started before the scan drained");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_RD)
    else $error("result raised outside a read request");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

endmodule
